// File: design/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg - scalar kalman filter shared types
// Control word layout, microcode program and register map of the filter unit.
// ----------------------------------------------------------------------------
package skf_pkg;

   localparam int CSR_WIDTH = 32;
   localparam logic [CSR_WIDTH-1:0] PROCESS_NOISE_RESET     = 32'd655;
   localparam logic [CSR_WIDTH-1:0] MEASUREMENT_NOISE_RESET = 32'd65536;

   typedef enum logic [0:0] {
      CSR_PROCESS_NOISE     = 1'b0,
      CSR_MEASUREMENT_NOISE = 1'b1
   } csr_index_type;

   localparam int STEP_WIDTH = 3;
   typedef logic [STEP_WIDTH-1:0] step_type;

   typedef enum logic [2:0] {
      OP_LOAD,
      OP_PRED,
      OP_DEN,
      OP_DIV,
      OP_GAIN,
      OP_MUL,
      OP_UPD,
      OP_EMIT
   } op_type;

   typedef enum logic [1:0] {
      JC_NEVER,
      JC_NO_REQ,
      JC_LOOP,
      JC_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctrl_word_type;

   // the step after the last one wraps to the wait step
   function automatic ctrl_word_type skf_rom(input step_type step);
      ctrl_word_type cw;
      unique case (step)
         3'd0: cw = '{op: OP_LOAD, cond: JC_NO_REQ,   target: 3'd0};
         3'd1: cw = '{op: OP_PRED, cond: JC_NEVER,    target: 3'd0};
         3'd2: cw = '{op: OP_DEN,  cond: JC_NEVER,    target: 3'd0};
         3'd3: cw = '{op: OP_DIV,  cond: JC_LOOP,     target: 3'd3};
         3'd4: cw = '{op: OP_GAIN, cond: JC_NEVER,    target: 3'd0};
         3'd5: cw = '{op: OP_MUL,  cond: JC_LOOP,     target: 3'd5};
         3'd6: cw = '{op: OP_UPD,  cond: JC_NEVER,    target: 3'd0};
         3'd7: cw = '{op: OP_EMIT, cond: JC_OUT_BUSY, target: 3'd7};
      endcase
      return cw;
   endfunction

endpackage

// File: design/scalar_kalman_filter_unit.sv
// ----------------------------------------------------------------------------
// scalar_kalman_filter_unit - first-order scalar kalman filter
// Microcoded sequencer over a divide/multiply datapath; one estimate per sample.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  req     | in        | req_valid/stall   | req_measurement (signed Q.FRAC)
//  rsp     | out       | rsp_valid/stall   | rsp_estimate_out (signed Q.FRAC)
//  csr     | in        | csr_write_enable  | csr_index, csr_write_data
//
//  an item runs from its beat to its result through the bit-serial gain
//  divide and the bit-serial multiply loop, each one quotient or multiplier
//  bit per cycle
//  one item at a time; the next beat can be taken in the cycle after the
//  result is registered
//  a stalled result holds the sequencer at its emit step
//  reset (synchronous) clears estimate and covariance and loads noise defaults
// ----------------------------------------------------------------------------
module scalar_kalman_filter_unit #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [DATA_WIDTH-1:0]        req_measurement,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [DATA_WIDTH-1:0]        rsp_estimate_out,
   input  logic                                csr_write_enable,
   input  skf_pkg::csr_index_type              csr_index,
   input  logic [skf_pkg::CSR_WIDTH-1:0]       csr_write_data
);
   import skf_pkg::*;

   localparam int DW     = DATA_WIDTH;
   localparam int SUM_W  = ((DW > CSR_WIDTH) ? DW : CSR_WIDTH) + 1;
   localparam int GAIN_W = FRAC_BITS + 1;
   localparam int P_W    = DW + FRAC_BITS + 2;
   localparam int CNT_W  = $clog2(GAIN_W + 1);
   localparam logic [GAIN_W-1:0] ONE_GAIN = {1'b1, {FRAC_BITS{1'b0}}};

   // sequencer
   step_type             step_ff, step_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   ctrl_word_type        cw;
   logic                 req_beat, out_free, cond_true;

   // state and configuration
   logic [CSR_WIDTH-1:0] process_noise_ff, measurement_noise_ff;
   logic [DW-1:0]        est_ff, est_in, cov_ff, cov_in;

   // datapath
   logic [DW-1:0]        meas_ff, meas_in;
   logic [DW-1:0]        pred_ff, pred_in;
   logic [DW:0]          mag_ff, mag_in;
   logic                 neg_ff, neg_in;
   logic [SUM_W-1:0]     den_ff, den_in;
   logic [SUM_W:0]       rem_ff, rem_in;
   logic [GAIN_W-1:0]    quo_ff, quo_in;
   logic [GAIN_W-1:0]    mb1_ff, mb1_in, mb2_ff, mb2_in;
   logic [P_W-1:0]       acc1_ff, acc1_in, acc2_ff, acc2_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]        rsp_est_ff, rsp_est_in;

   // combinational helpers
   logic [SUM_W-1:0]     pred_sum;
   logic [DW:0]          diff;
   logic [SUM_W:0]       trial;
   logic                 quo_bit;
   logic [SUM_W:0]       rem_keep;
   logic [GAIN_W-1:0]    gain;
   logic [DW:0]          corr, est_ext, est_new;

   assign cw        = skf_rom(step_ff);
   assign req_stall = (cw.op != OP_LOAD);
   assign req_beat  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      unique case (cw.cond)
         JC_NEVER:    cond_true = 1'b0;
         JC_NO_REQ:   cond_true = !req_beat;
         JC_LOOP:     cond_true = (cnt_ff != CNT_W'(1));
         JC_OUT_BUSY: cond_true = !out_free;
      endcase
      step_in = cond_true ? cw.target : step_ff + STEP_WIDTH'(1);
   end

   always_comb begin
      pred_sum = SUM_W'(cov_ff) + SUM_W'(process_noise_ff);
      diff     = {meas_ff[DW-1], meas_ff} - {est_ff[DW-1], est_ff};
      trial    = rem_ff - {1'b0, den_ff};
      quo_bit  = (rem_ff >= {1'b0, den_ff});
      rem_keep = quo_bit ? trial : rem_ff;
      // a zero denominator gives no gain at all
      gain     = (den_ff == '0) ? '0 : ((quo_ff > ONE_GAIN) ? ONE_GAIN : quo_ff);
      corr     = acc1_ff[FRAC_BITS +: DW+1];
      est_ext  = {est_ff[DW-1], est_ff};
      est_new  = neg_ff ? (est_ext - corr) : (est_ext + corr);

      meas_in      = meas_ff;
      pred_in      = pred_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      mb1_in       = mb1_ff;
      mb2_in       = mb2_ff;
      acc1_in      = acc1_ff;
      acc2_in      = acc2_ff;
      cnt_in       = cnt_ff;
      est_in       = est_ff;
      cov_in       = cov_ff;
      rsp_est_in   = rsp_est_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (cw.op)
         OP_LOAD: begin
            if (req_beat) meas_in = req_measurement;
         end
         OP_PRED: begin
            // covariance saturates at all ones
            pred_in = (pred_sum[SUM_W-1:DW] != '0) ? '1 : pred_sum[DW-1:0];
            neg_in  = diff[DW];
            mag_in  = diff[DW] ? (~diff + (DW+1)'(1)) : diff;
         end
         OP_DEN: begin
            den_in = SUM_W'(pred_ff) + SUM_W'(measurement_noise_ff);
            rem_in = (SUM_W+1)'(pred_ff);
            quo_in = '0;
            cnt_in = CNT_W'(GAIN_W);
         end
         OP_DIV: begin
            quo_in = {quo_ff[GAIN_W-2:0], quo_bit};
            rem_in = {rem_keep[SUM_W-1:0], 1'b0};
            cnt_in = cnt_ff - CNT_W'(1);
         end
         OP_GAIN: begin
            mb1_in  = gain;
            mb2_in  = ONE_GAIN - gain;
            acc1_in = '0;
            acc2_in = '0;
            cnt_in  = CNT_W'(GAIN_W);
         end
         OP_MUL: begin
            // msb-first shift and add, both products at once
            acc1_in = {acc1_ff[P_W-2:0], 1'b0} + (mb1_ff[GAIN_W-1] ? P_W'(mag_ff) : '0);
            acc2_in = {acc2_ff[P_W-2:0], 1'b0} + (mb2_ff[GAIN_W-1] ? P_W'(pred_ff) : '0);
            mb1_in  = {mb1_ff[GAIN_W-2:0], 1'b0};
            mb2_in  = {mb2_ff[GAIN_W-2:0], 1'b0};
            cnt_in  = cnt_ff - CNT_W'(1);
         end
         OP_UPD: begin
            est_in = est_new[DW-1:0];
            cov_in = acc2_ff[FRAC_BITS +: DW];
         end
         OP_EMIT: begin
            if (out_free) begin
               rsp_est_in   = est_ff;
               rsp_valid_in = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff              <= '0;
         cnt_ff               <= '0;
         rsp_valid_ff         <= 1'b0;
         est_ff               <= '0;
         cov_ff               <= '0;
         process_noise_ff     <= PROCESS_NOISE_RESET;
         measurement_noise_ff <= MEASUREMENT_NOISE_RESET;
      end else begin
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         est_ff       <= est_in;
         cov_ff       <= cov_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_PROCESS_NOISE:     process_noise_ff     <= csr_write_data;
               CSR_MEASUREMENT_NOISE: measurement_noise_ff <= csr_write_data;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      meas_ff    <= meas_in;
      pred_ff    <= pred_in;
      mag_ff     <= mag_in;
      neg_ff     <= neg_in;
      den_ff     <= den_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      mb1_ff     <= mb1_in;
      mb2_ff     <= mb2_in;
      acc1_ff    <= acc1_in;
      acc2_ff    <= acc2_in;
      rsp_est_ff <= rsp_est_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_estimate_out = rsp_est_ff;

   a_beat_starts_program: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> (step_ff == step_type'(1)))
      else $error("sample beat did not start the program");

   a_loop_count_live: assert property (@(posedge clock) disable iff (reset)
      (cw.op == OP_DIV || cw.op == OP_MUL) |-> (cnt_ff != '0))
      else $error("loop counter empty inside a loop step");

   a_quotient_bounded: assert property (@(posedge clock) disable iff (reset)
      (cw.op == OP_GAIN && den_ff != '0) |-> (quo_ff <= ONE_GAIN))
      else $error("gain quotient above one");

   a_cov_not_above_pred: assert property (@(posedge clock) disable iff (reset)
      $past(cw.op == OP_UPD) |-> (cov_ff <= $past(pred_ff)))
      else $error("covariance grew past the prediction");

   a_emit_loads_result: assert property (@(posedge clock) disable iff (reset)
      (cw.op == OP_EMIT && out_free) |=> (rsp_valid_ff && rsp_est_ff == $past(est_ff)))
      else $error("result not registered at emit");

endmodule

// File: verif/scalar_kalman_filter_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scalar_kalman_filter_unit_tb - self-checking bench for the kalman filter unit
// Streams measurement samples through the filter under several noise settings,
// with random gaps, output stalls and one long output hold. Every estimate is
// checked against a bit-exact fixed-point model of the filter update.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_unit_tb;
   import skf_pkg::*;

   localparam int FRAC        = 16;
   localparam logic [63:0] GAIN_ONE = 64'd1 << FRAC;
   localparam logic [63:0] DMAX     = 64'hFFFF_FFFF;
   localparam int QUIET_START = 5000;
   localparam int QUIET_END   = 11000;
   localparam int HOLD_START  = 15000;
   localparam int HOLD_CYCLES = 400;
   localparam int IDLE_PCT    = 12;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic signed [31:0]      req_measurement = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [31:0]      rsp_estimate_out;
   logic                    csr_write_enable = 1'b0;
   csr_index_type           csr_index = CSR_PROCESS_NOISE;
   logic [CSR_WIDTH-1:0]    csr_write_data = '0;

   // filter model state and its copy of the noise registers
   logic [31:0] filt_estimate   = '0;
   logic [31:0] filt_covariance = '0;
   logic [31:0] noise_q = PROCESS_NOISE_RESET;
   logic [31:0] noise_r = MEASUREMENT_NOISE_RESET;

   logic [31:0] sample_queue[$];
   logic [31:0] estimate_queue[$];

   int cycle_count     = 0;
   int samples_sent    = 0;
   int estimates_seen  = 0;
   int error_count     = 0;
   int settings_done   = 0;
   int hold_left       = 0;
   bit hold_done       = 1'b0;

   scalar_kalman_filter_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_measurement  (req_measurement),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_estimate_out (rsp_estimate_out),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // one filter step: predict, gain by restoring divide, correct, shrink covariance
   function automatic logic [31:0] kalman_update(input logic [31:0] meas);
      logic [63:0] pred;
      logic [63:0] den;
      logic [63:0] gain;
      logic [63:0] rem;
      logic [63:0] mag;
      logic [63:0] corr;
      logic [63:0] meas_x;
      logic [63:0] est_x;
      logic [63:0] diff;
      bit          neg;
      pred = {32'd0, filt_covariance} + {32'd0, noise_q};
      if (pred > DMAX) begin
         pred = DMAX;
      end
      den = pred + {32'd0, noise_r};
      gain = '0;
      if (den != 0) begin
         rem = pred;
         if (rem >= den) begin
            gain = 64'd1;
            rem  = rem - den;
         end
         for (int i = 0; i < FRAC; i++) begin
            rem  = rem << 1;
            gain = gain << 1;
            if (rem >= den) begin
               gain = gain | 64'd1;
               rem  = rem - den;
            end
         end
         if (gain > GAIN_ONE) begin
            gain = GAIN_ONE;
         end
      end
      meas_x = {{32{meas[31]}}, meas};
      est_x  = {{32{filt_estimate[31]}}, filt_estimate};
      diff   = meas_x - est_x;
      neg    = diff[63];
      mag    = neg ? (64'd0 - diff) : diff;
      corr   = (mag * gain) >> FRAC;
      est_x  = neg ? (est_x - corr) : (est_x + corr);
      filt_estimate   = est_x[31:0];
      filt_covariance = 32'(((pred * (GAIN_ONE - gain)) >> FRAC) & DMAX);
      return filt_estimate;
   endfunction

   // driver: offers queued samples, predicts on each accepted beat
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            estimate_queue.push_back(kalman_update(req_measurement));
            samples_sent++;
         end
         if (sample_queue.size() != 0 &&
             ((cycle_count >= QUIET_START && cycle_count < QUIET_END) ||
              $urandom_range(0, 99) >= IDLE_PCT)) begin
            req_valid       <= 1'b1;
            req_measurement <= sample_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: checks each estimate beat, drives random and long stalls
   always @(posedge clock) begin
      logic [31:0] want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            estimates_seen++;
            if (estimate_queue.size() == 0) begin
               $error("estimate_out: unexpected beat, actual %0d", rsp_estimate_out);
               error_count++;
            end else begin
               want = estimate_queue.pop_front();
               if (rsp_estimate_out !== want) begin
                  $error("estimate_out: expected %0d actual %0d",
                         $signed(want), rsp_estimate_out);
                  error_count++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (!hold_done && cycle_count >= HOLD_START &&
                      sample_queue.size() > 10) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else if (cycle_count >= QUIET_START && cycle_count < QUIET_END) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < IDLE_PCT);
         end
      end
   end

   task automatic write_csr(input csr_index_type idx, input logic [31:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      if (idx == CSR_PROCESS_NOISE) begin
         noise_q = value;
      end else begin
         noise_r = value;
      end
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (sample_queue.size() != 0 || req_valid || estimate_queue.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   function automatic logic [31:0] random_noise();
      case ($urandom_range(0, 4))
         0: return $urandom();
         1: return $urandom() >> $urandom_range(0, 31);
         2: return $urandom_range(0, 32'h20000);
         3: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
         default: return $urandom() >> 16;
      endcase
   endfunction

   function automatic logic [31:0] random_sample();
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = $urandom();
         4, 5: v = filt_estimate + $urandom_range(0, 32'h40000) - 32'h20000;
         6: begin
            case ($urandom_range(0, 3))
               0: v = 32'h7FFF_FFFF;
               1: v = 32'h8000_0000;
               2: v = 32'hFFFF_FFFF;
               default: v = 32'd0;
            endcase
         end
         7: begin
            v = $urandom() >> $urandom_range(1, 31);
            if ($urandom_range(0, 1) != 0) begin
               v = -v;
            end
         end
         default: v = $urandom();
      endcase
      return v;
   endfunction

   task automatic run_setting(input logic [31:0] q, input logic [31:0] r, input int count);
      write_csr(CSR_PROCESS_NOISE, q);
      write_csr(CSR_MEASUREMENT_NOISE, r);
      @(negedge clock);
      for (int i = 0; i < count; i++) begin
         sample_queue.push_back(random_sample());
      end
      wait_drained();
      settings_done++;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset noise values: extremes and alternating bit patterns
      @(negedge clock);
      sample_queue = '{32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'h8000_0000, 32'hFFFF_FFFF, 32'd1, 32'h0001_0000,
                       32'hFFFF_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0001_0000};
      wait_drained();
      settings_done++;

      // zero noise: gain goes to one, then the denominator hits zero
      write_csr(CSR_PROCESS_NOISE, 32'd0);
      write_csr(CSR_MEASUREMENT_NOISE, 32'd0);
      @(negedge clock);
      sample_queue = '{32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0};
      wait_drained();
      run_setting(32'd0, 32'd0, 60);

      // maximum noise: predicted covariance saturates
      write_csr(CSR_PROCESS_NOISE, 32'hFFFF_FFFF);
      write_csr(CSR_MEASUREMENT_NOISE, 32'hFFFF_FFFF);
      @(negedge clock);
      sample_queue = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF};
      wait_drained();
      run_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 100);

      run_setting(32'hFFFF_FFFF, 32'd0, 100);
      run_setting(32'd0, 32'hFFFF_FFFF, 100);
      run_setting(32'd1, 32'd1, 100);
      run_setting(PROCESS_NOISE_RESET, MEASUREMENT_NOISE_RESET, 120);
      for (int k = 0; k < 5; k++) begin
         run_setting(random_noise(), random_noise(), 84);
      end

      repeat (50) @(posedge clock);
      if (estimate_queue.size() != 0) begin
         $error("estimate_out: %0d expected beats never arrived", estimate_queue.size());
         error_count++;
      end
      $display("checked %0d estimates from %0d samples over %0d noise settings",
               estimates_seen, samples_sent, settings_done);
      $display("covered zero denominator, saturated covariance, extremes and a long hold");
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
   end

endmodule

// File: filelist.f
design/skf_pkg.sv
design/scalar_kalman_filter_unit.sv
verif/scalar_kalman_filter_unit_tb.sv
